/* design/chtbl_pkg.sv */
// chtbl_pkg: shared types and constants of the chained hash table
// request and result payload structs, field widths, operation codes, parameter defaults
// no dependencies
package chtbl_pkg;

    localparam int CFG_W  = 7;
    localparam int KEY_W  = 31;
    localparam int BIDX_W = 6;

    localparam int NUM_BUCKETS_DEF  = 64;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int KEY_BITS_DEF     = 31;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(64);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic              found;
        logic              overflow;
        logic [BIDX_W-1:0] bucket_index;
    } t_res;

endpackage

/* design/chtbl_mod.sv */
// chtbl_mod: serial restoring remainder unit, one dividend bit per cycle
// depends on chtbl_pkg for the divisor width
module chtbl_mod #(
    parameter int KEY_BITS = chtbl_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_BITS-1:0]        i_dividend,
    input  logic [chtbl_pkg::CFG_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [chtbl_pkg::CFG_W-1:0] o_rem
);
    import chtbl_pkg::*;

    localparam int CW = $clog2(KEY_BITS + 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [KEY_BITS-1:0] r_dvd;
    logic [CFG_W-1:0]  r_dsr;
    logic [CFG_W-1:0]  r_rem;

    logic [CFG_W:0]    trial;
    logic [CFG_W-1:0]  n_rem;

    // shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[KEY_BITS-1]};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = CFG_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = CFG_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(KEY_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[KEY_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* design/chained_hash_table.sv */
// chained_hash_table: hash table with fixed-depth buckets, insert and search
// depends on chtbl_pkg and chtbl_mod (serial remainder unit)
//
//  channel   signals                              transfer when
//  request   start, busy, i_req (t_req)           start & !busy
//  result    o_res_strobe, o_res (t_res)          o_res_strobe (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data i_cfg_valid & o_cfg_ready
//
// an item first runs through the serial remainder unit, then reads its bucket's fill
// count; an insert or a search of an empty bucket ends there, while any other search
// then reads one entry per cycle on the entry memory port until a hit or the last filled slot
// after reset a clearing pass zeroes the fill counts of all NUM_BUCKETS buckets,
// busy is high meanwhile; config writes are always taken
// results are shown for one cycle only; the receiver cannot stall
module chained_hash_table #(
    parameter int NUM_BUCKETS  = chtbl_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = chtbl_pkg::BUCKET_DEPTH_DEF,
    parameter int KEY_BITS     = chtbl_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  chtbl_pkg::t_req             i_req,
    output logic                        o_res_strobe,
    output chtbl_pkg::t_res             o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [chtbl_pkg::CFG_W-1:0] i_cfg_data
);
    import chtbl_pkg::*;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int ENTS   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ENT_AW = (ENTS > 1) ? $clog2(ENTS) : 1;
    localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FILL,
        S_SCAN
    } t_state;

    t_state              r_state, n_state;
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [BKT_W-1:0]    r_bkt, n_bkt;
    logic [ENT_AW-1:0]   r_base, n_base;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [BKT_W-1:0]    r_clr;
    logic [CFG_W-1:0]    r_tsize;
    logic                r_res_stb, n_res_stb;
    t_res                r_res, n_res;

    // memories and their registered read data
    logic [CNT_W-1:0]    fill_mem [NUM_BUCKETS];
    logic [KEY_BITS-1:0] ent_mem  [ENTS];
    logic [CNT_W-1:0]    r_fill;
    logic [KEY_BITS-1:0] r_ent;

    logic                fill_re, fill_we;
    logic [BKT_W-1:0]    fill_raddr, fill_waddr;
    logic [CNT_W-1:0]    fill_wdata;
    logic                ent_re, ent_we;
    logic [ENT_AW-1:0]   ent_raddr, ent_waddr;

    logic                accept;
    logic [CFG_W-1:0]    eff_size;
    logic                div_done;
    logic [CFG_W-1:0]    div_rem;
    logic                hit, last;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // table size saturates to 1..NUM_BUCKETS
    always_comb begin
        if (r_tsize == '0) begin
            eff_size = CFG_W'(1);
        end else if (32'(r_tsize) > NUM_BUCKETS) begin
            eff_size = CFG_W'(NUM_BUCKETS);
        end else begin
            eff_size = r_tsize;
        end
    end

    chtbl_mod #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_req.key_value[KEY_BITS-1:0]),
        .i_divisor  (eff_size),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign hit  = (r_ent == r_key);
    assign last = ((CNT_W'(r_slot) + CNT_W'(1)) == r_fill);

    always_comb begin
        n_state    = r_state;
        n_bkt      = r_bkt;
        n_base     = r_base;
        n_slot     = r_slot;
        n_res_stb  = 1'b0;
        n_res      = r_res;
        fill_re    = 1'b0;
        fill_raddr = BKT_W'(div_rem);
        fill_we    = 1'b0;
        fill_waddr = r_bkt;
        fill_wdata = r_fill + CNT_W'(1);
        ent_re     = 1'b0;
        ent_raddr  = r_base + ENT_AW'(r_slot) + ENT_AW'(1);
        ent_we     = 1'b0;
        ent_waddr  = r_base + ENT_AW'(r_fill);

        case (r_state)
            S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
                if (r_clr == BKT_W'(NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    fill_re = 1'b1;
                    n_bkt   = BKT_W'(div_rem);
                    n_base  = ENT_AW'(ENT_AW'(BKT_W'(div_rem)) * ENT_AW'(BUCKET_DEPTH));
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_res.bucket_index = BIDX_W'(r_bkt);
                n_res.found        = 1'b0;
                n_res.overflow     = 1'b0;
                if (r_op == OP_INSERT) begin
                    if (r_fill >= CNT_W'(BUCKET_DEPTH)) begin
                        n_res.overflow = 1'b1;
                    end else begin
                        ent_we  = 1'b1;
                        fill_we = 1'b1;
                    end
                    n_res_stb = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_fill == '0) begin
                    n_res_stb = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    ent_re    = 1'b1;
                    ent_raddr = r_base;
                    n_slot    = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // compare one entry while the next one is fetched
                if (hit || last) begin
                    n_res.found = hit;
                    n_res_stb   = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    ent_re = 1'b1;
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_tsize   <= TABLE_SIZE_RST;
            r_res_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_stb <= n_res_stb;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + BKT_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tsize <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.req_type;
            r_key <= i_req.key_value[KEY_BITS-1:0];
        end
        r_bkt  <= n_bkt;
        r_base <= n_base;
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill <= fill_mem[fill_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= r_key;
        end
        if (ent_re) begin
            r_ent <= ent_mem[ent_raddr];
        end
    end

    assign o_res_strobe = r_res_stb;
    assign o_res        = r_res;

endmodule

/* bench/chained_hash_table_checker.sv */
// chained_hash_table_checker: watches the request, result and config channels of the hash table
// keeps its own bucket store and table size, predicts each result and compares it field by field
// depends on chtbl_pkg
module chained_hash_table_checker
    import chtbl_pkg::*;
#(
    parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  t_req             i_req,
    input  logic             o_res_strobe,
    input  t_res             o_res,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_failures,
    output int               o_pending,
    output int               o_results,
    output int               o_hits,
    output int               o_overflows
);

    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    logic [KEY_W-1:0] stored_keys [NUM_BUCKETS*BUCKET_DEPTH];
    int unsigned      bucket_count [NUM_BUCKETS];
    logic [CFG_W-1:0] table_size;
    t_res             expected_res [$];

    // updates the bucket store as the block should and returns the result it owes
    function automatic t_res apply_request(t_req req);
        t_res             res;
        logic [KEY_W-1:0] key;
        int unsigned      modulus;
        int unsigned      bkt;
        int unsigned      fill;
        key = req.key_value & KEY_MASK;
        if (table_size == '0) begin
            modulus = 1;
        end else if (table_size > NUM_BUCKETS) begin
            modulus = NUM_BUCKETS;
        end else begin
            modulus = 32'(table_size);
        end
        bkt  = key % modulus;
        fill = bucket_count[bkt];
        res = '0;
        res.bucket_index = BIDX_W'(bkt);
        if (req.req_type == OP_INSERT) begin
            if (fill >= BUCKET_DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                stored_keys[bkt*BUCKET_DEPTH + fill] = key;
                bucket_count[bkt] = fill + 1;
            end
        end else begin
            // only filled slots are scanned
            for (int i = 0; i < fill; i++) begin
                if (stored_keys[bkt*BUCKET_DEPTH + i] == key) begin
                    res.found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(string field, int unsigned want, int unsigned got);
        o_failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                bucket_count[b] = 0;
            end
            table_size = TABLE_SIZE_RST;
            expected_res.delete();
            o_failures  = 0;
            o_results   = 0;
            o_hits      = 0;
            o_overflows = 0;
        end else begin
            if (o_res_strobe) begin
                o_results++;
                if (expected_res.size() == 0) begin
                    o_failures++;
                    $display("%0t: result with nothing expected, actual %h", $time, o_res);
                end else begin
                    want = expected_res.pop_front();
                    if (o_res.found !== want.found) begin
                        note_mismatch("found", want.found, o_res.found);
                    end
                    if (o_res.overflow !== want.overflow) begin
                        note_mismatch("overflow", want.overflow, o_res.overflow);
                    end
                    if (o_res.bucket_index !== want.bucket_index) begin
                        note_mismatch("bucket_index", want.bucket_index, o_res.bucket_index);
                    end
                    if (want.found) begin
                        o_hits++;
                    end
                    if (want.overflow) begin
                        o_overflows++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                table_size = i_cfg_data;
            end
            if (start && !busy) begin
                expected_res.push_back(apply_request(i_req));
            end
        end
        o_pending = expected_res.size();
    end

endmodule

/* bench/chained_hash_table_tb.sv */
// chained_hash_table_tb: stimulus and verdict for the chained hash table
// directed corner cases, then random insert/search phases over several table sizes
// depends on chtbl_pkg, chained_hash_table and chained_hash_table_checker
module chained_hash_table_tb;
    import chtbl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 60;   // longest search plus margin
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 200;
    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_res_strobe;
    t_res             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int failures, pending, results, hits, overflows;
    int idle_cycles = 0;
    int settings_used = 1;
    bit no_idle = 1'b0;
    logic [CFG_W-1:0] cur_size = TABLE_SIZE_RST;
    logic [KEY_W-1:0] key_pool [$];

    always #5 i_clk = ~i_clk;

    chained_hash_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    chained_hash_table_checker u_table_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_results   (results),
        .o_hits      (hits),
        .o_overflows (overflows)
    );

    // called at a falling edge; start stays high when the next request follows at once
    task automatic issue(logic op, logic [KEY_W-1:0] key);
        int   gap;
        t_req req;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.req_type  = op;
        req.key_value = key;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (op == OP_INSERT) begin
            key_pool.push_back(key);
        end
    endtask

    task automatic set_table_size(logic [CFG_W-1:0] size);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_size = size;
        settings_used++;
    endtask

    task automatic random_request();
        int unsigned      hint;
        int unsigned      sel;
        logic [KEY_W-1:0] key;
        logic             op;
        hint = (cur_size == '0) ? 1 : ((cur_size > NUM_BUCKETS_DEF) ? NUM_BUCKETS_DEF : cur_size);
        op   = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_SEARCH;
        sel  = $urandom_range(0, 9);
        key  = KEY_W'($urandom);
        if (op == OP_INSERT) begin
            if (sel >= 5 && sel < 8) begin
                key = KEY_W'($urandom_range(0, 255));
            end else if (sel >= 8 && key_pool.size() > 0) begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
        end else if (key_pool.size() > 0 && sel < 8) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            // same bucket, most likely a different key
            if (sel >= 6) begin
                key = KEY_W'(key + hint * $urandom_range(1, 8));
            end
        end else if (sel == 9) begin
            key = KEY_W'($urandom_range(0, 255));
        end
        issue(op, key);
    endtask

    initial begin
        logic [CFG_W-1:0] sizes [N_PHASES];
        sizes = '{7'd64, 7'd37, 7'd127, 7'd2, 7'd63, 7'd0, 7'd65, 7'd1};
        sizes[1] = CFG_W'($urandom_range(1, 64));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size 64 from reset
        issue(OP_INSERT, '0);
        issue(OP_SEARCH, '0);
        issue(OP_INSERT, '0);
        issue(OP_INSERT, KEY_TOP);
        issue(OP_SEARCH, KEY_TOP);
        issue(OP_SEARCH, KEY_W'(KEY_TOP - 64));
        issue(OP_SEARCH, KEY_W'(64));
        issue(OP_SEARCH, KEY_W'(10));
        // fill bucket 5 past its depth
        for (int k = 0; k < 9; k++) begin
            issue(OP_INSERT, KEY_W'(5 + 64 * k));
        end
        issue(OP_INSERT, KEY_W'(5));
        issue(OP_SEARCH, KEY_W'(5 + 64 * 7));
        issue(OP_SEARCH, KEY_W'(5 + 64 * 9));
        issue(OP_SEARCH, KEY_W'(32'h5555_5555));
        issue(OP_INSERT, KEY_W'(32'h2AAA_AAAA));

        // shrinking the table keeps stored keys where they were
        set_table_size(7'd1);
        issue(OP_INSERT, KEY_W'(1));
        issue(OP_SEARCH, '0);
        issue(OP_SEARCH, KEY_W'(5));

        for (int p = 0; p < N_PHASES; p++) begin
            set_table_size(sizes[p]);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 29) == 0) begin
                    no_idle = !no_idle;
                end
                random_request();
            end
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d requests over %0d table-size settings", results, settings_used);
        $display("searches that hit: %0d, inserts that overflowed: %0d", hits, overflows);
        if (failures == 0 && pending == 0) begin
            $display("[chained_hash_table] OK");
        end else begin
            $display("[chained_hash_table] ERROR");
        end
        $finish;
    end

    // stall watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles at %0t", idle_cycles, $time);
            $display("[chained_hash_table] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
